// ===== hw/rtl/playfair_digraph_cipher_core_macros.svh =====
// Assertion macros for the Playfair core RTL.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_CORE_MACROS_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PFC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pfc_pkg.sv =====
// Types, constants and helper functions for the Playfair core.
`default_nettype none
package pfc_pkg;

  localparam int LETTERS = 26;
  localparam int CELLS   = 25;

  localparam logic [4:0] IDX_I     = 5'd8;
  localparam logic [4:0] IDX_J     = 5'd9;
  localparam logic [4:0] IDX_X     = 5'd23;
  localparam logic [4:0] IDX_LAST  = 5'd25;
  localparam logic [4:0] CELLS_N   = 5'd25;
  localparam logic [2:0] SIDE_MAX  = 3'd4;

  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5a;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7a;
  localparam logic [7:0] CASE_GAP  = 8'd32;
  localparam logic [6:0] ASCII_A   = 7'd65;

  typedef enum logic [1:0] {
    KIND_KEY  = 2'd0,
    KIND_DONE = 2'd1,
    KIND_TEXT = 2'd2,
    KIND_END  = 2'd3
  } kind_t;

  typedef struct packed {
    logic       valid;
    logic [4:0] idx;
  } letter_t;

  // one write into the key square: cell holds letter, letter sits at cell
  typedef struct packed {
    logic       en;
    logic [4:0] pos;
    logic [4:0] letter;
  } key_wr_t;

  // uppercase, fold J onto I, flag non-letters
  function automatic letter_t to_letter(logic [7:0] c);
    logic [7:0] u;
    letter_t    r;
    u = (c >= CH_LO_A && c <= CH_LO_Z) ? c - CASE_GAP : c;
    r.valid = (u >= CH_UP_A) && (u <= CH_UP_Z);
    r.idx   = 5'(u - CH_UP_A);
    if (r.idx == IDX_J) r.idx = IDX_I;
    return r;
  endfunction

  // row of a cell index 0..24
  function automatic logic [2:0] cell_row(logic [4:0] pos);
    if (pos >= 5'd20)      return 3'd4;
    else if (pos >= 5'd15) return 3'd3;
    else if (pos >= 5'd10) return 3'd2;
    else if (pos >= 5'd5)  return 3'd1;
    else                   return 3'd0;
  endfunction

  function automatic logic [4:0] times_side(logic [2:0] r);
    return {r, 2'b00} + {2'b00, r};
  endfunction

  function automatic logic [2:0] cell_col(logic [4:0] pos);
    return 3'(pos - times_side(cell_row(pos)));
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pfc_if.sv =====
// Stream and configuration interfaces of the Playfair core.
`default_nettype none
interface pfc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] in_char;
  modport source (output valid, kind, in_char, input ready);
  modport sink   (input valid, kind, in_char, output ready);
endinterface

interface pfc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       last_of_pair;
  modport source (output valid, out_char, last_of_pair, input ready);
  modport sink   (input valid, out_char, last_of_pair, output ready);
endinterface

interface pfc_cfg_if;
  logic valid;
  logic ready;
  logic decrypt_mode;
  modport source (output valid, decrypt_mode, input ready);
  modport sink   (input valid, decrypt_mode, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/playfair_digraph_cipher_core.sv =====
// Top level of the Playfair digraph cipher core.
// Key bytes build a 5x5 square; a key-done transaction runs a 26-step fill
// sequencer (one letter A..Z per cycle) and the core takes no input until the
// fill is done. A text byte that only becomes the held letter, and any dropped
// byte, leaves the core idle. A text byte or end of text that completes a
// digraph passes through two registered lookups in the single-read
// letter-to-cell memory, one shared cell-rule unit used for each letter in
// turn, two reads of the cell-to-letter memory, then the two result letters
// leave one per cycle, while the output is free, through the output register.
// The core takes no input while a digraph is in flight; decrypt_mode is written
// through its own channel, which is always ready.
`default_nettype none
`include "playfair_digraph_cipher_core_macros.svh"
module playfair_digraph_cipher_core (
  input  wire logic clk,
  input  wire logic rst,
  pfc_in_if.sink    in_item,
  pfc_out_if.source out_item,
  pfc_cfg_if.sink   cfg
);
  import pfc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FILL, ST_PA, ST_PB, ST_X1, ST_X2, ST_E1, ST_E2
  } state_t;

  state_t               state;
  logic                 decrypt_mode;
  logic [LETTERS-1:0]   letter_used;
  logic [4:0]           fill_count;
  logic [4:0]           fill_idx;
  logic                 key_complete;
  logic [4:0]           held_letter;
  logic                 held_valid;
  logic [4:0]           pair_b;
  logic [4:0]           place_a;
  logic [4:0]           place_b;
  logic [4:0]           first_letter;
  logic                 out_valid;
  logic [6:0]           out_char;
  logic                 out_last;

  logic                 accept;
  logic                 out_free;
  logic                 out_load;
  kind_t                kind;
  letter_t              li;
  logic [4:0]           fill_eff;
  logic                 used_eff;
  logic [LETTERS-1:0]   used_key;
  key_wr_t              wr;
  logic [4:0]           place_rd_addr;
  logic [4:0]           place_q;
  logic                 cell_rd_en;
  logic [4:0]           cell_q;
  logic [4:0]           own_cell;
  logic [4:0]           other_cell;
  logic [4:0]           target_cell;

  assign accept   = in_item.valid && in_item.ready;
  assign out_free = !out_valid || out_item.ready;
  assign out_load = ((state == ST_E1) || (state == ST_E2)) && out_free;
  assign kind     = kind_t'(in_item.kind);
  assign li       = to_letter(in_item.in_char);

  assign in_item.ready         = (state == ST_IDLE);
  assign out_item.valid        = out_valid;
  assign out_item.out_char     = out_char;
  assign out_item.last_of_pair = out_last;
  assign cfg.ready             = 1'b1;

  // a key byte after a complete key starts from an empty square
  assign fill_eff = key_complete ? 5'd0 : fill_count;
  assign used_eff = key_complete ? 1'b0 : letter_used[li.idx];

  // square write port: key bytes in idle, unused letters during fill
  always_comb begin
    wr = '0;
    if (state == ST_IDLE) begin
      wr.en     = accept && (kind == KIND_KEY) && li.valid && !used_eff
                  && (fill_eff < CELLS_N);
      wr.pos    = fill_eff;
      wr.letter = li.idx;
    end else if (state == ST_FILL) begin
      wr.en     = (fill_idx != IDX_J) && !letter_used[fill_idx] && (fill_count < CELLS_N);
      wr.pos    = fill_count;
      wr.letter = fill_idx;
    end
  end

  // used-letter set after a key byte: emptied by a new key, then marked
  always_comb begin
    used_key = key_complete ? '0 : letter_used;
    if (wr.en) used_key[wr.letter] = 1'b1;
  end

  // lookup addressing: held letter read in idle, partner in the next cycle
  assign place_rd_addr = (state == ST_PA) ? pair_b : held_letter;
  assign cell_rd_en    = (state == ST_X1) || (state == ST_X2);
  assign own_cell      = (state == ST_X2) ? place_b : place_a;
  assign other_cell    = (state == ST_X2) ? place_a : place_b;

  pfc_key_store u_store (
    .clk           (clk),
    .wr            (wr),
    .place_rd_addr (place_rd_addr),
    .place_rd_data (place_q),
    .cell_rd_en    (cell_rd_en),
    .cell_rd_addr  (target_cell),
    .cell_rd_data  (cell_q)
  );

  pfc_cell_unit u_cell (
    .own_cell    (own_cell),
    .other_cell  (other_cell),
    .decrypt     (decrypt_mode),
    .target_cell (target_cell)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_mode <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      decrypt_mode <= cfg.decrypt_mode;
    end
  end

  // sequencer, key bookkeeping and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      letter_used  <= '0;
      fill_count   <= '0;
      fill_idx     <= '0;
      key_complete <= 1'b0;
      held_letter  <= '0;
      held_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_item.ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (kind)
              KIND_KEY: begin
                if (key_complete) begin
                  key_complete <= 1'b0;
                  held_valid   <= 1'b0;
                end
                letter_used <= used_key;
                fill_count  <= wr.en ? fill_eff + 5'd1 : fill_eff;
              end
              KIND_DONE: begin
                if (!key_complete) begin
                  fill_idx <= '0;
                  state    <= ST_FILL;
                end
              end
              KIND_TEXT: begin
                if (key_complete && li.valid) begin
                  held_letter <= li.idx;
                  if (!held_valid) begin
                    held_valid <= 1'b1;
                  end else begin
                    // doubled letter in encipher mode pairs with X and stays held
                    if (!decrypt_mode && li.idx == held_letter) begin
                      pair_b <= IDX_X;
                    end else begin
                      pair_b     <= li.idx;
                      held_valid <= 1'b0;
                    end
                    state <= ST_PA;
                  end
                end
              end
              KIND_END: begin
                if (key_complete && held_valid) begin
                  held_valid <= 1'b0;
                  pair_b     <= IDX_X;
                  state      <= ST_PA;
                end
              end
              default: ;
            endcase
          end
        end
        ST_FILL: begin
          if (wr.en) begin
            letter_used[fill_idx] <= 1'b1;
            fill_count            <= fill_count + 5'd1;
          end
          fill_idx <= fill_idx + 5'd1;
          if (fill_idx == IDX_LAST) begin
            key_complete <= 1'b1;
            held_valid   <= 1'b0;
            state        <= ST_IDLE;
          end
        end
        ST_PA: begin
          place_a <= place_q;
          state   <= ST_PB;
        end
        ST_PB: begin
          place_b <= place_q;
          state   <= ST_X1;
        end
        ST_X1: begin
          state <= ST_X2;
        end
        ST_X2: begin
          first_letter <= cell_q;
          state        <= ST_E1;
        end
        ST_E1: begin
          if (out_free) begin
            out_char  <= ASCII_A + {2'b00, first_letter};
            out_last  <= 1'b0;
            state     <= ST_E2;
          end
        end
        ST_E2: begin
          if (out_free) begin
            out_char  <= ASCII_A + {2'b00, cell_q};
            out_last  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a complete key always fills all 25 cells
  `PFC_ASSERT_IMPL(a_full_key, clk, rst, key_complete, fill_count == CELLS_N, "key complete with square not full")
  // a held text letter only exists under a complete key
  `PFC_ASSERT_IMPL(a_held_key, clk, rst, held_valid, key_complete, "held letter without complete key")
  // the second letter of a digraph is marked as such
  `PFC_ASSERT_NEXT(a_second, clk, rst, (state == ST_E2) && out_free, out_item.valid && out_item.last_of_pair, "second letter not flagged")

endmodule
`default_nettype wire

// ===== hw/rtl/pfc_key_store.sv =====
// Key square storage: cell-to-letter and letter-to-cell memories.
`default_nettype none
module pfc_key_store (
  input  wire logic            clk,
  input  wire pfc_pkg::key_wr_t wr,
  input  wire logic [4:0]      place_rd_addr,
  output logic [4:0]           place_rd_data,
  input  wire logic            cell_rd_en,
  input  wire logic [4:0]      cell_rd_addr,
  output logic [4:0]           cell_rd_data
);
  import pfc_pkg::*;

  logic [4:0] square_cells [CELLS];
  logic [4:0] letter_place [LETTERS];

  // both maps are written together
  always_ff @(posedge clk) begin
    if (wr.en) begin
      square_cells[wr.pos]    <= wr.letter;
      letter_place[wr.letter] <= wr.pos;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    place_rd_data <= letter_place[place_rd_addr];
    if (cell_rd_en) cell_rd_data <= square_cells[cell_rd_addr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pfc_cell_unit.sv =====
// Digraph rule: target cell of one letter given its partner's cell.
`default_nettype none
module pfc_cell_unit (
  input  wire logic [4:0] own_cell,
  input  wire logic [4:0] other_cell,
  input  wire logic       decrypt,
  output logic [4:0]      target_cell
);
  import pfc_pkg::*;

  logic [2:0] r1, c1, r2, c2;

  function automatic logic [2:0] wrap_step(logic [2:0] v, logic dec);
    if (dec) return (v == 3'd0) ? SIDE_MAX : v - 3'd1;
    else     return (v == SIDE_MAX) ? 3'd0 : v + 3'd1;
  endfunction

  assign r1 = cell_row(own_cell);
  assign c1 = cell_col(own_cell);
  assign r2 = cell_row(other_cell);
  assign c2 = cell_col(other_cell);

  // same row shifts columns, same column shifts rows, else rectangle
  always_comb begin
    if (r1 == r2)      target_cell = times_side(r1) + {2'b00, wrap_step(c1, decrypt)};
    else if (c1 == c2) target_cell = times_side(wrap_step(r1, decrypt)) + {2'b00, c1};
    else               target_cell = times_side(r1) + {2'b00, c2};
  end

endmodule
`default_nettype wire
